// ===== rtl/core/message_control_code_parser_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the message control code parser
// Concurrent checks with a clock and an active-low reset.
// ----------------------------------------------------------------------------
`ifndef MESSAGE_CONTROL_CODE_PARSER_ASSERT_SVH
`define MESSAGE_CONTROL_CODE_PARSER_ASSERT_SVH

// Same-cycle implication.
`define MCCP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MCCP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/msgcc_pkg.sv =====
// ----------------------------------------------------------------------------
// msgcc_pkg
// Types, character codes and output sequence table of the message parser.
// ----------------------------------------------------------------------------
package msgcc_pkg;

  typedef enum logic [1:0] {
    MODE_TEXT,
    MODE_HEX1,
    MODE_HEX2,
    MODE_SKIP
  } mode_e;

  typedef enum logic [1:0] {
    CMD_CHAR,
    CMD_START,
    CMD_CLEAR,
    CMD_ATTR
  } cmd_kind_e;

  typedef logic [4:0] step_t;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [7:0]  char_val;
    logic [9:0]  value;
  } cmd_t;

  typedef struct packed {
    mode_e mode;
    logic  stopped;
  } front_stat_t;

  typedef struct packed {
    logic  busy;
    step_t step;
  } back_stat_t;

  // Character codes
  localparam logic [7:0] CH_ETX   = 8'h03;
  localparam logic [7:0] CH_BEL   = 8'h07;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SI    = 8'd15;
  localparam logic [7:0] CH_CAN   = 8'd24;
  localparam logic [7:0] CH_SUB   = 8'd26;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  // Steps of the shared output sequence: setup runs the whole table,
  // clear/home runs its tail, an attribute runs the color code section.
  localparam step_t STEP_START_FIRST = 5'd0;
  localparam step_t STEP_ATTR_FIRST  = 5'd11;
  localparam step_t STEP_HUND        = 5'd13;
  localparam step_t STEP_TENS        = 5'd14;
  localparam step_t STEP_ONES        = 5'd15;
  localparam step_t STEP_ATTR_LAST   = 5'd15;
  localparam step_t STEP_CLEAR_FIRST = 5'd22;
  localparam step_t STEP_SEQ_LAST    = 5'd28;

  localparam logic [10:0] START_ATTR = 11'd7;
  localparam logic [9:0]  DEC_MAX    = 10'd999;

  function automatic logic [7:0] seq_byte(step_t step);
    logic [7:0] b;
    unique case (step)
      5'd0:    b = CH_ESC;
      5'd1:    b = 8'h65;   // e
      5'd2:    b = CH_ESC;
      5'd3:    b = 8'h25;   // %
      5'd4:    b = 8'h40;   // @
      5'd5:    b = CH_ESC;
      5'd6:    b = 8'h29;   // )
      5'd7:    b = 8'h30;   // 0
      5'd8:    b = CH_ESC;
      5'd9:    b = 8'h28;   // (
      5'd10:   b = 8'h42;   // B
      5'd11:   b = CH_ETX;
      5'd12:   b = 8'h23;   // #
      5'd16:   b = CH_ESC;
      5'd17:   b = 8'h5B;   // [
      5'd18:   b = 8'h3F;   // ?
      5'd19:   b = 8'h32;   // 2
      5'd20:   b = 8'h35;   // 5
      5'd21:   b = 8'h6C;   // l
      5'd22:   b = CH_ESC;
      5'd23:   b = 8'h5B;   // [
      5'd24:   b = 8'h32;   // 2
      5'd25:   b = 8'h4A;   // J
      5'd26:   b = CH_ESC;
      5'd27:   b = 8'h5B;   // [
      5'd28:   b = 8'h48;   // H
      default: b = 8'h00;   // digit steps are filled in by the sequencer
    endcase
    return b;
  endfunction

  function automatic logic [3:0] hex_value(logic [7:0] c);
    logic [3:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = 4'(c - 8'h37);
    end else begin
      v = 4'd0;
    end
    return v;
  endfunction

  function automatic logic [9:0] sat_dec(logic [10:0] v);
    logic [9:0] r;
    if (v > {1'b0, DEC_MAX}) begin
      r = DEC_MAX;
    end else begin
      r = v[9:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/msgcc_in_if.sv =====
// ----------------------------------------------------------------------------
// msgcc_in_if
// Request channel into the parser: valid/ready with type and message byte.
// ----------------------------------------------------------------------------
interface msgcc_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] char_in;

  modport source (output valid, output req_type, output char_in, input ready);
  modport sink   (input valid, input req_type, input char_in, output ready);
endinterface

// ===== rtl/core/msgcc_out_if.sv =====
// ----------------------------------------------------------------------------
// msgcc_out_if
// Console byte channel out of the parser: valid/ready with byte and last.
// ----------------------------------------------------------------------------
interface msgcc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       last;

  modport source (output valid, output char_out, output last, input ready);
  modport sink   (input valid, input char_out, input last, output ready);
endinterface

// ===== rtl/core/msgcc_front.sv =====
// ----------------------------------------------------------------------------
// msgcc_front
// Accepts requests, tracks the parse mode and turns bytes into commands.
// ----------------------------------------------------------------------------
module msgcc_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  msgcc_in_if.sink             in_if,
  input  logic [9:0]           base_i,
  input  logic                 q_full_i,
  output logic                 push_o,
  output msgcc_pkg::cmd_t      cmd_o,
  output msgcc_pkg::front_stat_t stat_o
);
  import msgcc_pkg::*;

  mode_e      mode_q, mode_d;
  logic [3:0] hi_q, hi_d;
  logic       stop_q, stop_d;
  logic       accept;
  logic [7:0] c;
  logic [3:0] lo;

  assign in_if.ready = !q_full_i;
  assign accept      = in_if.valid && in_if.ready;
  assign c           = in_if.char_in;
  assign lo          = hex_value(c);

  always_comb begin
    mode_d         = mode_q;
    hi_d           = hi_q;
    stop_d         = stop_q;
    push_o         = 1'b0;
    cmd_o.kind     = CMD_CHAR;
    cmd_o.char_val = c;
    cmd_o.value    = '0;
    if (accept) begin
      if (!in_if.req_type) begin
        mode_d      = MODE_TEXT;
        hi_d        = 4'd0;
        stop_d      = 1'b0;
        push_o      = 1'b1;
        cmd_o.kind  = CMD_START;
        cmd_o.value = sat_dec({1'b0, base_i} + START_ATTR);
      end else if (!stop_q) begin
        unique case (mode_q)
          MODE_HEX1: begin
            hi_d   = lo;
            mode_d = MODE_HEX2;
          end
          MODE_HEX2: begin
            push_o      = 1'b1;
            cmd_o.kind  = CMD_ATTR;
            cmd_o.value = sat_dec({3'b0, hi_q, lo} + {1'b0, base_i});
            mode_d      = MODE_TEXT;
          end
          MODE_SKIP: begin
            if (c == CH_LF) begin
              mode_d = MODE_TEXT;
            end
          end
          default: begin
            mode_d = MODE_TEXT;
            if (c == CH_FF) begin
              push_o     = 1'b1;
              cmd_o.kind = CMD_CLEAR;
            end else if (c == CH_SI) begin
              mode_d = MODE_HEX1;
            end else if (c == CH_CAN) begin
              mode_d = MODE_SKIP;
            end else if (c == CH_SUB) begin
              stop_d = 1'b1;
            end else if (c == CH_BEL || c == CH_LF || c == CH_CR || c >= CH_SPACE) begin
              push_o = 1'b1;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_TEXT;
      hi_q   <= 4'd0;
      stop_q <= 1'b0;
    end else begin
      mode_q <= mode_d;
      hi_q   <= hi_d;
      stop_q <= stop_d;
    end
  end

  assign stat_o.mode    = mode_q;
  assign stat_o.stopped = stop_q;

endmodule

// ===== rtl/core/msgcc_queue.sv =====
// ----------------------------------------------------------------------------
// msgcc_queue
// Short command queue between the parser front and the output sequencer.
// ----------------------------------------------------------------------------
module msgcc_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  msgcc_pkg::cmd_t cmd_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output msgcc_pkg::cmd_t cmd_o
);
  import msgcc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  cmd_t            entry_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = entry_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrLast) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrLast) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/msgcc_back.sv =====
// ----------------------------------------------------------------------------
// msgcc_back
// Output sequencer: expands commands into console bytes, one per ready cycle.
// ----------------------------------------------------------------------------
module msgcc_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  empty_i,
  input  msgcc_pkg::cmd_t       head_i,
  output logic                  pop_o,
  msgcc_out_if.source           out_if,
  output msgcc_pkg::back_stat_t stat_o
);
  import msgcc_pkg::*;

  logic       busy_q, busy_d;
  step_t      step_q, step_d;
  step_t      end_q, end_d;
  logic [9:0] val_q;
  logic [3:0] hund_q;
  logic [6:0] rem_q;
  logic [3:0] tens_q;
  logic       ovld_q, ovld_d;
  logic [7:0] ochar_q, ochar_d;
  logic       olast_q, olast_d;

  logic        advance;
  logic [20:0] hund_prod;
  logic [9:0]  hund_sub;
  logic [9:0]  rem_full;
  logic [14:0] tens_prod;
  logic [3:0]  tens_cur;
  logic [6:0]  ones_full;
  logic [7:0]  step_byte;

  // Digits: value/100 by reciprocal, then remainder/10 by reciprocal.
  assign hund_prod = {11'b0, val_q} * 21'd1311;
  assign hund_sub  = {6'b0, hund_q} * 10'd100;
  assign rem_full  = val_q - hund_sub;
  assign tens_prod = {8'b0, rem_q} * 15'd205;
  assign tens_cur  = tens_prod[14:11];
  assign ones_full = rem_q - 7'({3'b0, tens_q} * 7'd10);

  always_comb begin
    case (step_q)
      STEP_HUND: step_byte = CH_ZERO + {4'b0, hund_q};
      STEP_TENS: step_byte = CH_ZERO + {4'b0, tens_cur};
      STEP_ONES: step_byte = CH_ZERO + {4'b0, ones_full[3:0]};
      default:   step_byte = seq_byte(step_q);
    endcase
  end

  assign advance = !ovld_q || out_if.ready;
  assign pop_o   = advance && !busy_q && !empty_i;

  always_comb begin
    busy_d  = busy_q;
    step_d  = step_q;
    end_d   = end_q;
    ovld_d  = ovld_q;
    ochar_d = ochar_q;
    olast_d = olast_q;
    if (advance) begin
      ovld_d = 1'b0;
      if (busy_q) begin
        ovld_d  = 1'b1;
        ochar_d = step_byte;
        olast_d = (step_q == end_q);
        step_d  = step_q + 1'b1;
        busy_d  = (step_q != end_q);
      end else if (pop_o) begin
        ovld_d  = 1'b1;
        olast_d = 1'b0;
        busy_d  = 1'b1;
        unique case (head_i.kind)
          CMD_CHAR: begin
            ochar_d = head_i.char_val;
            olast_d = 1'b1;
            busy_d  = 1'b0;
          end
          CMD_START: begin
            ochar_d = seq_byte(STEP_START_FIRST);
            step_d  = STEP_START_FIRST + 1'b1;
            end_d   = STEP_SEQ_LAST;
          end
          CMD_CLEAR: begin
            ochar_d = seq_byte(STEP_CLEAR_FIRST);
            step_d  = STEP_CLEAR_FIRST + 1'b1;
            end_d   = STEP_SEQ_LAST;
          end
          CMD_ATTR: begin
            ochar_d = seq_byte(STEP_ATTR_FIRST);
            step_d  = STEP_ATTR_FIRST + 1'b1;
            end_d   = STEP_ATTR_LAST;
          end
          default: begin
            ovld_d = 1'b0;
            busy_d = 1'b0;
          end
        endcase
      end
    end
  end

  // Digit pipeline settles within the bytes that precede the digits.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      val_q <= head_i.value;
    end
    hund_q  <= hund_prod[20:17];
    rem_q   <= rem_full[6:0];
    tens_q  <= tens_cur;
    ochar_q <= ochar_d;
    olast_q <= olast_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      end_q  <= '0;
      ovld_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
      end_q  <= end_d;
      ovld_q <= ovld_d;
    end
  end

  assign out_if.valid    = ovld_q;
  assign out_if.char_out = ochar_q;
  assign out_if.last     = olast_q;
  assign stat_o.busy     = busy_q;
  assign stat_o.step     = step_q;

endmodule

// ===== rtl/core/message_control_code_parser.sv =====
// A request is held in the command queue, then in the output byte register.
// Throughput: one request per cycle while each yields at most one byte and
// the console is ready; expansions stream one byte per cycle while it is
// ready (setup 29, clear 7, attribute 5); the next command follows directly.
// Reset: asynchronous, clears parser mode, stop flag, queue, sequencer and
// the color base to zero; no clearing pass.
// ----------------------------------------------------------------------------
// message_control_code_parser
// Message text to console byte translator with setup, clear and color codes.
// ----------------------------------------------------------------------------
`include "message_control_code_parser_assert.svh"

module message_control_code_parser #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  msgcc_in_if.sink   in_if,
  msgcc_out_if.source out_if,
  input  logic       cfg_we_i,
  input  logic [9:0] cfg_wdata_i
);
  import msgcc_pkg::*;

  logic [9:0]  base_q;
  logic        q_push, q_full, q_pop, q_empty;
  cmd_t        q_in, q_head;
  front_stat_t fr_stat;
  back_stat_t  bk_stat;
  logic        start_acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
    end else if (cfg_we_i) begin
      base_q <= cfg_wdata_i;
    end
  end

  msgcc_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_if    (in_if),
    .base_i   (base_q),
    .q_full_i (q_full),
    .push_o   (q_push),
    .cmd_o    (q_in),
    .stat_o   (fr_stat)
  );

  msgcc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .cmd_o   (q_head)
  );

  msgcc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (q_empty),
    .head_i  (q_head),
    .pop_o   (q_pop),
    .out_if  (out_if),
    .stat_o  (bk_stat)
  );

  assign start_acc = in_if.valid && in_if.ready && !in_if.req_type;

  `MCCP_ASSERT_IMP(a_start_pushes, clk_i, rst_ni, start_acc, q_push && !q_full, "start request not queued")
  `MCCP_ASSERT_IMP(a_stopped_drops, clk_i, rst_ni, fr_stat.stopped && in_if.valid && in_if.ready && in_if.req_type, !q_push, "data queued while stopped")
  `MCCP_ASSERT_NXT(a_stop_holds, clk_i, rst_ni, fr_stat.stopped && !start_acc, fr_stat.stopped, "stop cleared without start")
  `MCCP_ASSERT_IMP(a_step_range, clk_i, rst_ni, bk_stat.busy, bk_stat.step >= 5'd1 && bk_stat.step <= STEP_SEQ_LAST, "sequencer step out of range")

endmodule
